@@ rtl/mps_pkg.sv @@
// Package for the matrix power series block.
// Sizes, codes and the digit reduction used by all files but mps_ram.
package mps_pkg;

  localparam int MAX_DIM = 32;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int DIM_W   = IDX_W + 1;
  localparam int DIGIT_W = 4;
  localparam int POW_W   = 30;
  localparam int BIT_W   = $clog2(POW_W);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_DIM   = 1'b0,
    REG_POWER = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIND  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    PS_ZERO,
    PS_COPY_A,
    PS_MUL_SP,
    PS_ADD_ST,
    PS_MUL_PP,
    PS_COPY_TP1,
    PS_MUL_PA,
    PS_COPY_TP2,
    PS_ADD_SP
  } pass_e;

  // v below 128: quotient by 205/2048
  function automatic logic [DIGIT_W-1:0] mod10(input logic [6:0] v);
    logic [17:0] prod;
    logic [6:0]  quo;
    logic [6:0]  rem;
    prod = 18'(v) * 18'd205;
    quo  = 7'(prod >> 11);
    rem  = v - 7'(quo * 7'd10);
    return rem[DIGIT_W-1:0];
  endfunction

endpackage

@@ rtl/mps_if.sv @@
// Channel interfaces of the matrix power series block.
// Depends on mps_pkg for the result_value width.
interface mps_item_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [4:0]                 row_index;
  logic [4:0]                 col_index;
  logic [3:0]                 element_value;
  modport source (output valid, opcode, row_index, col_index, element_value, input ready);
  modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mps_result_if;
  logic                       valid;
  logic                       ready;
  logic [mps_pkg::DIGIT_W-1:0] result_value;
  logic                       out_of_range;
  modport source (output valid, result_value, out_of_range, input ready);
  modport sink   (input valid, result_value, out_of_range, output ready);
endinterface

@@ rtl/mps_ram.sv @@
// Generic RAM: one write port, two registered read ports.
// No package dependency.
module mps_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

@@ rtl/matrix_power_series_mod.sv @@
// Top level: matrix geometric series modulo 10 by doubling.
// Depends on mps_pkg, mps_if and mps_ram.
//
//  channel   dir  transaction
//  item_i    in   opcode, row_index, col_index, element_value
//  result_o  out  result_value, out_of_range (reads only)
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// A write goes into the A RAM when accepted; a read passes the RAM read register, then the output register.
// A start runs passes over n*n cells: copy and add passes visit each cell once, a multiply steps the
// inner index per cell, each pass ends in one drain state, and each bit of k takes 2 to 3 multiplies.
// No clearing pass after reset; stores are valid once written.
// item_i stalls during a start and while a read result waits on result_o.
module matrix_power_series_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mps_item_if.sink                     item_i,
  mps_result_if.source                 result_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [mps_pkg::POW_W-1:0]    cfg_data_i
);

  localparam int IW = mps_pkg::IDX_W;
  localparam int AW = mps_pkg::ADDR_W;
  localparam int DW = mps_pkg::DIGIT_W;
  localparam int NW = mps_pkg::DIM_W;

  logic [5:0]                  dim_q;
  logic [mps_pkg::POW_W-1:0]   pow_q;
  mps_pkg::state_e             state_q, state_d;
  mps_pkg::pass_e              pass_q, pass_d;
  logic [mps_pkg::BIT_W-1:0]   bits_q, bits_d;
  logic [NW-1:0]               n_q, n_d, n_eff, n_m1;
  logic [IW-1:0]               r_q, r_d, c_q, c_d, t_q, t_d;
  logic                        s1_valid_q, s1_first_q, s1_last_q;
  logic [AW-1:0]               s1_waddr_q;
  logic [DW-1:0]               acc_q;
  logic                        rd_pend_q, rd_oor_q;
  logic                        out_valid_q;
  logic [DW-1:0]               out_value_q;
  logic                        out_oor_q;

  logic                        accept, is_mul, t_last, c_last, r_last, cell_done;
  logic                        kbit;
  logic [AW-1:0]               addr0, addr1, cell_addr;
  logic [DW-1:0]               a_rd0, a_rd1, p_rd0, p_rd1, s_rd0, s_rd1, t_rd0, t_rd1;
  logic [DW-1:0]               mx, my, mul_res, s_wdata, p_wdata, in_digit;
  logic [6:0]                  mul_sum;
  logic                        a_we, s_we, p_we, t_we;
  logic                        row_ok;

  always_comb begin
    if (int'(dim_q) > mps_pkg::MAX_DIM) begin
      n_eff = NW'(mps_pkg::MAX_DIM);
    end else begin
      n_eff = NW'(dim_q);
    end
  end

  assign accept = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == mps_pkg::ST_IDLE) && !rd_pend_q &&
                        (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= 6'd1;
      pow_q <= mps_pkg::POW_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mps_pkg::REG_DIM:   dim_q <= cfg_data_i[5:0];
        mps_pkg::REG_POWER: pow_q <= cfg_data_i;
        default:            dim_q <= dim_q;
      endcase
    end
  end

  // Pass counters and sequencing
  assign is_mul = (pass_q == mps_pkg::PS_MUL_SP) || (pass_q == mps_pkg::PS_MUL_PP) ||
                  (pass_q == mps_pkg::PS_MUL_PA);
  assign n_m1   = n_q - NW'(1);
  assign t_last = !is_mul || (NW'(t_q) == n_m1);
  assign c_last = (NW'(c_q) == n_m1);
  assign r_last = (NW'(r_q) == n_m1);
  assign cell_done = t_last && c_last && r_last;
  assign kbit   = pow_q[bits_q - mps_pkg::BIT_W'(1)];

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    bits_d  = bits_q;
    n_d     = n_q;
    r_d     = r_q;
    c_d     = c_q;
    t_d     = t_q;
    case (state_q)
      mps_pkg::ST_IDLE: begin
        r_d = '0;
        c_d = '0;
        t_d = '0;
        if (accept && item_i.opcode == mps_pkg::OP_START && n_eff != '0) begin
          n_d = n_eff;
          if (pow_q == '0) begin
            pass_d  = mps_pkg::PS_ZERO;
            state_d = mps_pkg::ST_RUN;
          end else begin
            bits_d  = mps_pkg::BIT_W'(mps_pkg::POW_W - 1);
            state_d = mps_pkg::ST_FIND;
          end
        end
      end
      mps_pkg::ST_FIND: begin
        if (pow_q[bits_q]) begin
          pass_d  = mps_pkg::PS_COPY_A;
          state_d = mps_pkg::ST_RUN;
        end else begin
          bits_d = bits_q - mps_pkg::BIT_W'(1);
        end
      end
      mps_pkg::ST_RUN: begin
        if (cell_done) begin
          state_d = mps_pkg::ST_DRAIN;
          r_d = '0;
          c_d = '0;
          t_d = '0;
        end else if (!t_last) begin
          t_d = t_q + IW'(1);
        end else begin
          t_d = '0;
          if (c_last) begin
            c_d = '0;
            r_d = r_q + IW'(1);
          end else begin
            c_d = c_q + IW'(1);
          end
        end
      end
      mps_pkg::ST_DRAIN: begin
        state_d = mps_pkg::ST_RUN;
        case (pass_q)
          mps_pkg::PS_ZERO: state_d = mps_pkg::ST_IDLE;
          mps_pkg::PS_COPY_A: begin
            if (bits_q == '0) begin
              state_d = mps_pkg::ST_IDLE;
            end else begin
              pass_d = mps_pkg::PS_MUL_SP;
            end
          end
          mps_pkg::PS_MUL_SP:   pass_d = mps_pkg::PS_ADD_ST;
          mps_pkg::PS_ADD_ST:   pass_d = mps_pkg::PS_MUL_PP;
          mps_pkg::PS_MUL_PP:   pass_d = mps_pkg::PS_COPY_TP1;
          mps_pkg::PS_MUL_PA:   pass_d = mps_pkg::PS_COPY_TP2;
          mps_pkg::PS_COPY_TP2: pass_d = mps_pkg::PS_ADD_SP;
          mps_pkg::PS_COPY_TP1: begin
            if (kbit) begin
              pass_d = mps_pkg::PS_MUL_PA;
            end else begin
              bits_d = bits_q - mps_pkg::BIT_W'(1);
              if (bits_d == '0) begin
                state_d = mps_pkg::ST_IDLE;
              end else begin
                pass_d = mps_pkg::PS_MUL_SP;
              end
            end
          end
          mps_pkg::PS_ADD_SP: begin
            bits_d = bits_q - mps_pkg::BIT_W'(1);
            if (bits_d == '0) begin
              state_d = mps_pkg::ST_IDLE;
            end else begin
              pass_d = mps_pkg::PS_MUL_SP;
            end
          end
          default: state_d = mps_pkg::ST_IDLE;
        endcase
      end
      default: state_d = mps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mps_pkg::ST_IDLE;
      pass_q     <= mps_pkg::PS_ZERO;
      bits_q     <= '0;
      n_q        <= NW'(1);
      r_q        <= '0;
      c_q        <= '0;
      t_q        <= '0;
      s1_valid_q <= 1'b0;
      rd_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pass_q     <= pass_d;
      bits_q     <= bits_d;
      n_q        <= n_d;
      r_q        <= r_d;
      c_q        <= c_d;
      t_q        <= t_d;
      s1_valid_q <= (state_q == mps_pkg::ST_RUN);
      rd_pend_q  <= accept && item_i.opcode == mps_pkg::OP_READ;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Read addresses: in multiply passes row-by-inner for port 0, inner-by-column for port 1; else the cell or item
  assign cell_addr = {r_q, c_q};
  always_comb begin
    if (state_q == mps_pkg::ST_RUN) begin
      addr0 = is_mul ? {r_q, t_q} : cell_addr;
      addr1 = is_mul ? {t_q, c_q} : cell_addr;
    end else begin
      addr0 = {IW'(item_i.row_index), IW'(item_i.col_index)};
      addr1 = addr0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= (t_q == '0);
    s1_last_q  <= t_last;
    s1_waddr_q <= cell_addr;
    if (s1_valid_q) begin
      acc_q <= mul_res;
    end
    rd_oor_q <= !row_ok;
    if (rd_pend_q) begin
      out_value_q <= rd_oor_q ? '0 : s_rd0;
      out_oor_q   <= rd_oor_q;
    end
  end

  assign row_ok = (int'(item_i.row_index) < int'(n_eff)) &&
                  (int'(item_i.col_index) < int'(n_eff));

  // Stage 1: multiply-accumulate and elementwise ops
  always_comb begin
    case (pass_q)
      mps_pkg::PS_MUL_SP: begin
        mx = s_rd0;
        my = p_rd1;
      end
      mps_pkg::PS_MUL_PP: begin
        mx = p_rd0;
        my = p_rd1;
      end
      default: begin
        mx = p_rd0;
        my = a_rd1;
      end
    endcase
  end

  assign mul_sum = 7'(mx) * 7'(my) + (s1_first_q ? 7'd0 : 7'(acc_q));
  assign mul_res = mps_pkg::mod10(mul_sum);

  always_comb begin
    case (pass_q)
      mps_pkg::PS_ADD_ST: s_wdata = mps_pkg::mod10(7'(s_rd0) + 7'(t_rd0));
      mps_pkg::PS_ADD_SP: s_wdata = mps_pkg::mod10(7'(s_rd0) + 7'(p_rd0));
      mps_pkg::PS_COPY_A: s_wdata = a_rd0;
      default:            s_wdata = '0;
    endcase
  end

  assign p_wdata = (pass_q == mps_pkg::PS_COPY_A) ? a_rd0 : t_rd0;
  assign s_we = s1_valid_q && ((pass_q == mps_pkg::PS_COPY_A) ||
                (pass_q == mps_pkg::PS_ADD_ST) || (pass_q == mps_pkg::PS_ADD_SP) ||
                (pass_q == mps_pkg::PS_ZERO));
  assign p_we = s1_valid_q && ((pass_q == mps_pkg::PS_COPY_A) ||
                (pass_q == mps_pkg::PS_COPY_TP1) || (pass_q == mps_pkg::PS_COPY_TP2));
  assign t_we = s1_valid_q && is_mul && s1_last_q;

  assign in_digit = (item_i.element_value >= 4'd10) ? item_i.element_value - 4'd10
                                                    : item_i.element_value;
  assign a_we = accept && item_i.opcode == mps_pkg::OP_WRITE &&
                int'(item_i.row_index) < mps_pkg::MAX_DIM &&
                int'(item_i.col_index) < mps_pkg::MAX_DIM;

  mps_ram #(.WIDTH(DW), .DEPTH(mps_pkg::CELLS)) u_a_ram (
    .clk_i, .we_i(a_we), .waddr_i(addr0), .wdata_i(in_digit),
    .raddr0_i(addr0), .raddr1_i(addr1), .rdata0_o(a_rd0), .rdata1_o(a_rd1)
  );

  mps_ram #(.WIDTH(DW), .DEPTH(mps_pkg::CELLS)) u_p_ram (
    .clk_i, .we_i(p_we), .waddr_i(s1_waddr_q), .wdata_i(p_wdata),
    .raddr0_i(addr0), .raddr1_i(addr1), .rdata0_o(p_rd0), .rdata1_o(p_rd1)
  );

  mps_ram #(.WIDTH(DW), .DEPTH(mps_pkg::CELLS)) u_s_ram (
    .clk_i, .we_i(s_we), .waddr_i(s1_waddr_q), .wdata_i(s_wdata),
    .raddr0_i(addr0), .raddr1_i(addr1), .rdata0_o(s_rd0), .rdata1_o(s_rd1)
  );

  mps_ram #(.WIDTH(DW), .DEPTH(mps_pkg::CELLS)) u_t_ram (
    .clk_i, .we_i(t_we), .waddr_i(s1_waddr_q), .wdata_i(mul_res),
    .raddr0_i(addr0), .raddr1_i(addr1), .rdata0_o(t_rd0), .rdata1_o(t_rd1)
  );

  assign result_o.valid        = out_valid_q;
  assign result_o.result_value = out_value_q;
  assign result_o.out_of_range = out_oor_q;

endmodule

@@ dv/matrix_power_series_mod_tb.sv @@
`timescale 1ns / 1ps
// Testbench for matrix_power_series_mod: directed table, then phased random stimulus.
// Depends on mps_pkg, mps_if and the RTL; checks reads via table or series predictor.
module matrix_power_series_mod_tb;

  typedef logic [3:0] mat_t [mps_pkg::MAX_DIM][mps_pkg::MAX_DIM];
  typedef struct packed {
    logic [3:0] value;
    logic       oor;
  } read_t;
  typedef struct {
    mps_pkg::op_e op;
    int           r;
    int           c;
    int           v;
    bit           typed;
    logic [3:0]   ev;
    logic         eo;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [mps_pkg::POW_W-1:0] cfg_data_i = '0;

  mps_item_if   item ();
  mps_result_if res ();

  matrix_power_series_mod dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .item_i(item), .result_o(res),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  mat_t a_mat, s_mat;
  bit   s_ok [mps_pkg::MAX_DIM][mps_pkg::MAX_DIM];
  int unsigned dim_q = 1;
  int unsigned pow_q = 1;
  read_t read_q[$];
  int   errors = 0;
  int   send_idle = 0;
  int   recv_stall = 0;

  initial begin
    item.valid = 1'b0;
    item.opcode = mps_pkg::OP_NONE;
    item.row_index = '0;
    item.col_index = '0;
    item.element_value = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk_i) res.ready <= ($urandom_range(0, 99) >= recv_stall);

  always @(posedge clk_i) begin
    read_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (read_q.size() == 0) begin
        $display("%0t: unexpected read transaction value=%0d oor=%0b", $time,
                 res.result_value, res.out_of_range);
        errors++;
      end else begin
        want = read_q.pop_front();
        if (res.result_value !== want.value) begin
          $display("%0t: result_value expected %0d actual %0d", $time, want.value,
                   res.result_value);
          errors++;
        end
        if (res.out_of_range !== want.oor) begin
          $display("%0t: out_of_range expected %0b actual %0b", $time, want.oor,
                   res.out_of_range);
          errors++;
        end
      end
    end
  end

  function automatic int eff_n();
    return (dim_q > mps_pkg::MAX_DIM) ? mps_pkg::MAX_DIM : dim_q;
  endfunction

  function automatic mat_t mat_mul(mat_t x, mat_t y, int n);
    mat_t z;
    int acc;
    z = x;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        acc = 0;
        for (int t = 0; t < n; t++) acc += int'(x[r][t]) * int'(y[t][c]);
        z[r][c] = 4'(acc % 10);
      end
    return z;
  endfunction

  function automatic mat_t mat_add(mat_t x, mat_t y, int n);
    mat_t z;
    z = x;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) z[r][c] = 4'((int'(x[r][c]) + int'(y[r][c])) % 10);
    return z;
  endfunction

  function automatic void series_sum();
    int n;
    int top;
    mat_t p, t;
    n = eff_n();
    if (n == 0) return;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) s_ok[r][c] = 1'b1;
    if (pow_q == 0) begin
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) s_mat[r][c] = '0;
      return;
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) s_mat[r][c] = a_mat[r][c];
    p = s_mat;
    top = 29;
    while (pow_q[top] == 1'b0) top--;
    for (int b = top - 1; b >= 0; b--) begin
      t = mat_mul(s_mat, p, n);
      s_mat = mat_add(s_mat, t, n);
      p = mat_mul(p, p, n);
      if (pow_q[b]) begin
        p = mat_mul(p, a_mat, n);
        s_mat = mat_add(s_mat, p, n);
      end
    end
  endfunction

  function automatic read_t predict_read(int r, int c);
    read_t o;
    if (r < eff_n() && c < eff_n()) begin
      o.value = s_mat[r][c];
      o.oor = 1'b0;
    end else begin
      o.value = '0;
      o.oor = 1'b1;
    end
    return o;
  endfunction

  task automatic send(mps_pkg::op_e op, int r, int c, int v, bit typed = 0,
                      logic [3:0] ev = 0, logic eo = 0);
    read_t o;
    if ($urandom_range(0, 99) < send_idle) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    item.valid <= 1'b1;
    item.opcode <= op;
    item.row_index <= 5'(r);
    item.col_index <= 5'(c);
    item.element_value <= 4'(v);
    @(posedge clk_i);
    while (!item.ready) @(posedge clk_i);
    case (op)
      mps_pkg::OP_WRITE: a_mat[r][c] = 4'(v % 10);
      mps_pkg::OP_READ: begin
        o = predict_read(r, c);
        if (typed) begin
          o.value = ev;
          o.oor = eo;
        end
        read_q = {read_q, o};
      end
      mps_pkg::OP_START: series_sum();
      default: ;
    endcase
  endtask

  task automatic settle();
    item.valid <= 1'b0;
    @(posedge clk_i);
    while (!(item.ready && read_q.size() == 0)) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(mps_pkg::reg_e idx, int unsigned data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= mps_pkg::POW_W'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mps_pkg::REG_DIM) dim_q = data & 6'h3f;
    else pow_q = data & 30'h3fffffff;
  endtask

  task automatic random_read(int n);
    int r, c;
    r = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 31) : $urandom_range(0, n);
    c = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 31) : $urandom_range(0, n);
    if (r > 31) r = 31;
    if (c > 31) c = 31;
    if (r < eff_n() && c < eff_n() && !s_ok[r][c]) r = 31 > eff_n() ? 31 : r;
    if (r < eff_n() && c < eff_n() && !s_ok[r][c]) return;
    send(mps_pkg::OP_READ, r, c, 0);
  endtask

  row_t table_rows[] = '{
    '{mps_pkg::OP_WRITE, 0, 0, 9, 0, 0, 0},
    '{mps_pkg::OP_START, 0, 0, 0, 0, 0, 0},
    '{mps_pkg::OP_READ, 0, 0, 0, 1, 9, 0},
    '{mps_pkg::OP_READ, 1, 0, 0, 1, 0, 1},
    '{mps_pkg::OP_READ, 0, 31, 0, 1, 0, 1},
    '{mps_pkg::OP_READ, 31, 31, 0, 1, 0, 1},
    '{mps_pkg::OP_WRITE, 0, 0, 15, 0, 0, 0},
    '{mps_pkg::OP_WRITE, 31, 31, 7, 0, 0, 0},
    '{mps_pkg::OP_WRITE, 5, 3, 0, 0, 0, 0},
    '{mps_pkg::OP_NONE, 0, 0, 0, 0, 0, 0},
    '{mps_pkg::OP_NONE, 31, 31, 15, 0, 0, 0},
    '{mps_pkg::OP_START, 0, 0, 0, 0, 0, 0},
    '{mps_pkg::OP_READ, 0, 0, 0, 1, 5, 0},
    '{mps_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0},
    '{mps_pkg::OP_START, 0, 0, 0, 0, 0, 0},
    '{mps_pkg::OP_READ, 0, 0, 0, 1, 0, 0},
    '{mps_pkg::OP_READ, 0, 1, 0, 1, 0, 1}
  };

  int unsigned fixed_dim[] = '{2, 3, 2, 0, 4, 5, 8, 1, 6, 2};
  int unsigned fixed_pow[] = '{1, 2, 0, 5, 30'h3fffffff, 1, 2, 30'h3fffffff, 1, 30'h2aaaaaaa};

  initial begin
    int unsigned d, k;
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    foreach (table_rows[i])
      send(table_rows[i].op, table_rows[i].r, table_rows[i].c, table_rows[i].v,
           table_rows[i].typed, table_rows[i].ev, table_rows[i].eo);
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 70; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 70; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      if (p < fixed_dim.size()) begin
        d = fixed_dim[p];
        k = fixed_pow[p];
      end else begin
        d = $urandom_range(1, 6);
        k = $urandom & ((32'd1 << $urandom_range(1, 30)) - 1);
      end
      settle();
      cfg_write(mps_pkg::REG_DIM, d);
      cfg_write(mps_pkg::REG_POWER, k);
      n = eff_n();
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) send(mps_pkg::OP_WRITE, r, c, $urandom_range(0, 15));
      send(mps_pkg::OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
           $urandom_range(0, 15));
      send(mps_pkg::OP_START, $urandom_range(0, 31), $urandom_range(0, 31),
           $urandom_range(0, 15));
      for (int i = 0; i < 16; i++) begin
        if (p == 3 && i == 10) begin
          item.valid <= 1'b0;
          @(posedge clk_i);
          while (read_q.size() != 0) @(posedge clk_i);
        end
        case ($urandom_range(0, 19))
          0, 1, 2: send(mps_pkg::OP_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 15));
          3: send(mps_pkg::OP_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, 15));
          default: random_read(n);
        endcase
      end
      if (p % 5 == 2 && n > 1) begin
        settle();
        cfg_write(mps_pkg::REG_DIM, n - 1);
        for (int i = 0; i < 8; i++) random_read(n);
      end
    end
    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("matrix_power_series_mod_tb: clean");
    else $display("matrix_power_series_mod_tb: errors");
    $finish;
  end

  initial begin
    #8000000;
    $display("matrix_power_series_mod_tb: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/mps_pkg.sv
rtl/mps_if.sv
rtl/mps_ram.sv
rtl/matrix_power_series_mod.sv
dv/matrix_power_series_mod_tb.sv
